FILE: rtl/acpa_pkg.sv
package acpa_pkg;

   // internal fixed point: Q60 on magnitudes, sign kept apart
   localparam int WF = 60;
   localparam int MAG_W = 63;
   localparam int Z_W = 61;
   localparam int QUOT_W = 62;
   localparam logic [127:0] DEC_SCALE = 128'd1000000000000000000;

   typedef struct packed {
      logic             neg;
      logic [MAG_W-1:0] mag;
   } sm_type;

   // floor(dec * 2^60 / 10^18), only evaluated at elaboration
   function automatic logic [63:0] q60_of(input logic [63:0] dec);
      logic [127:0] w;
      w = {64'd0, dec} << WF;
      w = w / DEC_SCALE;
      return w[63:0];
   endfunction

   // numerator (is_den low) and denominator coefficients, zero above degree six
   function automatic sm_type coef_sm(input logic is_den, input int k);
      logic [63:0] dec;
      logic [63:0] v;
      logic        neg;
      sm_type      r;
      dec = 64'd0;
      neg = 1'b0;
      if (!is_den) begin
         unique case (k)
            0: dec = 64'd166666666666666667;
            1: begin dec = 64'd451834677893154506; neg = 1'b1; end
            2: dec = 64'd452683382858399539;
            3: begin dec = 64'd204511700745869575; neg = 1'b1; end
            4: dec = 64'd40161699156136797;
            5: begin dec = 64'd2604361227231504; neg = 1'b1; end
            6: dec = 64'd8529836515897;
            default: dec = 64'd0;
         endcase
      end else begin
         unique case (k)
            0: dec = 64'd1000000000000000000;
            1: begin dec = 64'd3161008067358927034; neg = 1'b1; end
            2: dec = 64'd3870696784604771541;
            3: begin dec = 64'd2304476834742890138; neg = 1'b1; end
            4: dec = 64'd683183463380740736;
            5: begin dec = 64'd91189047491786683; neg = 1'b1; end
            6: dec = 64'd3926844788854131;
            default: dec = 64'd0;
         endcase
      end
      v = q60_of(dec);
      r.neg = neg;
      r.mag = v[MAG_W-1:0];
      return r;
   endfunction

   localparam logic [63:0] HALF_PI = q60_of(64'd1570796326794896619);
   localparam logic [63:0] PI = HALF_PI << 1;
   localparam logic [63:0] ONE_Q60 = 64'd1 << WF;

endpackage

FILE: rtl/acpa_mul.sv
module acpa_mul #(
   parameter int LANES  = 1,
   parameter int SIDE_W = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   input  logic [LANES-1:0][acpa_pkg::MAG_W-1:0]  in_a,
   input  logic [acpa_pkg::Z_W-1:0]               in_b,
   input  logic [SIDE_W-1:0]                      in_side,
   output logic                                   out_valid,
   output logic [LANES-1:0][acpa_pkg::MAG_W-1:0]  out_prod,
   output logic [SIDE_W-1:0]                      out_side
);

   // floor(a*b / 2^60) from four 32-bit partial products, two stages

   localparam int AH_W = acpa_pkg::MAG_W - 32;
   localparam int BH_W = acpa_pkg::Z_W - 32;
   localparam int SUM_W = acpa_pkg::MAG_W + acpa_pkg::Z_W;

   logic [LANES-1:0][63:0]        ll_ff;
   logic [LANES-1:0][BH_W+31:0]   lh_ff;
   logic [LANES-1:0][AH_W+31:0]   hl_ff;
   logic [LANES-1:0][AH_W+BH_W-1:0] hh_ff;
   logic [LANES-1:0][acpa_pkg::MAG_W-1:0] prod_ff;
   logic                          v1_ff;
   logic                          v2_ff;
   logic [SIDE_W-1:0]             side1_ff;
   logic [SIDE_W-1:0]             side2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      side1_ff <= in_side;
      side2_ff <= side1_ff;
   end

   genvar l;
   generate
      for (l = 0; l < LANES; l++) begin : g_lane
         logic [SUM_W-1:0] sum;

         always_ff @(posedge clock) begin
            ll_ff[l] <= in_a[l][31:0] * in_b[31:0];
            lh_ff[l] <= in_a[l][31:0] * in_b[acpa_pkg::Z_W-1:32];
            hl_ff[l] <= in_a[l][acpa_pkg::MAG_W-1:32] * in_b[31:0];
            hh_ff[l] <= in_a[l][acpa_pkg::MAG_W-1:32] * in_b[acpa_pkg::Z_W-1:32];
         end

         always_comb begin
            sum = SUM_W'(ll_ff[l]) + (SUM_W'(lh_ff[l]) << 32) + (SUM_W'(hl_ff[l]) << 32)
                + (SUM_W'(hh_ff[l]) << 64);
         end

         always_ff @(posedge clock) begin
            prod_ff[l] <= sum[acpa_pkg::WF +: acpa_pkg::MAG_W];
         end
      end
   endgenerate

   assign out_valid = v2_ff;
   assign out_prod  = prod_ff;
   assign out_side  = side2_ff;

endmodule

FILE: rtl/acpa_div.sv
module acpa_div #(
   parameter int SIDE_W = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [acpa_pkg::MAG_W-1:0]    in_dividend,
   input  acpa_pkg::sm_type              in_divisor,
   input  logic [SIDE_W-1:0]             in_side,
   output logic                          out_valid,
   output logic [acpa_pkg::QUOT_W-1:0]   out_quot,
   output logic [SIDE_W-1:0]             out_side
);

   // floor(a * 2^60 / b), saturated below 4.0; two quotient bits a stage

   localparam int BITS_PER_STAGE = 2;
   localparam int STAGES = acpa_pkg::WF / BITS_PER_STAGE;
   localparam int MW = acpa_pkg::MAG_W;

   typedef struct packed {
      logic                        sat;
      logic [MW-1:0]               rem;
      logic [MW-1:0]               dvs;
      logic [acpa_pkg::QUOT_W-1:0] quot;
   } div_state_type;

   div_state_type     st_ff   [STAGES+1];
   div_state_type     st_in   [STAGES+1];
   logic              vld_ff  [STAGES+1];
   logic              vld_in  [STAGES+1];
   logic [SIDE_W-1:0] side_ff [STAGES+1];
   logic [SIDE_W-1:0] side_in [STAGES+1];

   genvar s;
   generate
      for (s = 0; s <= STAGES; s++) begin : g_st
         if (s == 0) begin : g_pre
            // integer part of the quotient first, saturate at four or more
            always_comb begin
               logic [MW:0] a1;
               logic [MW:0] a2;
               logic        ge2;
               logic        ge1;
               ge2 = {1'b0, in_dividend} >= {in_divisor.mag, 1'b0};
               a1  = ge2 ? ({1'b0, in_dividend} - {in_divisor.mag, 1'b0})
                         : {1'b0, in_dividend};
               ge1 = a1 >= {1'b0, in_divisor.mag};
               a2  = ge1 ? (a1 - {1'b0, in_divisor.mag}) : a1;
               st_in[0].sat  = in_divisor.neg || (in_divisor.mag == '0)
                               || ({2'b00, in_dividend} >= {in_divisor.mag, 2'b00});
               st_in[0].rem  = a2[MW-1:0];
               st_in[0].dvs  = in_divisor.mag;
               st_in[0].quot = {{(acpa_pkg::QUOT_W-2){1'b0}}, ge2, ge1};
            end
            assign vld_in[0]  = in_valid;
            assign side_in[0] = in_side;
         end else begin : g_step
            always_comb begin
               div_state_type nxt;
               logic [MW:0]   r2;
               logic          ge;
               nxt = st_ff[s-1];
               for (int i = 0; i < BITS_PER_STAGE; i++) begin
                  r2 = {nxt.rem, 1'b0};
                  ge = r2 >= {1'b0, nxt.dvs};
                  if (ge) begin
                     r2 = r2 - {1'b0, nxt.dvs};
                  end
                  nxt.rem  = r2[MW-1:0];
                  nxt.quot = {nxt.quot[acpa_pkg::QUOT_W-2:0], ge};
               end
               st_in[s] = nxt;
            end
            assign vld_in[s]  = vld_ff[s-1];
            assign side_in[s] = side_ff[s-1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else begin
               vld_ff[s] <= vld_in[s];
            end
            st_ff[s]   <= st_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   endgenerate

   assign out_valid = vld_ff[STAGES];
   assign out_quot  = st_ff[STAGES].sat ? '1 : st_ff[STAGES].quot;
   assign out_side  = side_ff[STAGES];

endmodule

FILE: rtl/arccos_pade_approximant_top.sv
// arccos of one signed fixed-point argument per item, as a rational approximation
//
// input channel: drive req_x_value (two's complement, FRAC_BITS fraction bits) and
//   raise start; the item is taken at that clock edge when busy is low. busy never
//   rises, so an item can be taken on every cycle
// result channel: rsp_valid is high for exactly one cycle with rsp_angle (unsigned,
//   FRAC_BITS fraction bits, 0..pi); the receiver must take it in that cycle
// latency: 3*POLY_DEGREE + 41 cycles from start to rsp_valid (59 by default),
//   set by the chain of 64-bit multiplies (two stages each), the Horner adds and the
//   31-stage radix-4 divider; throughput one item per cycle, results in input order
// reset (synchronous, active high) drops every valid bit in the pipe, so items in
//   flight are discarded and no result appears until a new item is taken
// there is no back-pressure: nothing holds, every stage advances each cycle
module arccos_pade_approximant_top #(
   parameter int FRAC_BITS   = 30,
   parameter int POLY_DEGREE = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_x_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_angle
);

   localparam int SH = acpa_pkg::WF - FRAC_BITS;
   localparam logic [63:0] ONE_IN = 64'd1 << FRAC_BITS;
   localparam logic [63:0] ROUND_HALF = 64'd1 << (SH - 1);
   localparam int MW = acpa_pkg::MAG_W;
   localparam int ZW = acpa_pkg::Z_W;

   typedef struct packed {
      logic          xneg;
      logic [ZW-1:0] m;
   } front_type;

   typedef struct packed {
      acpa_pkg::sm_type p;
      acpa_pkg::sm_type q;
      logic [ZW-1:0]    z;
      logic             xneg;
      logic [ZW-1:0]    m;
   } horn_type;

   typedef struct packed {
      logic          pneg;
      logic          qneg;
      logic [ZW-1:0] z;
      logic          xneg;
      logic [ZW-1:0] m;
   } hside_type;

   typedef struct packed {
      logic             pneg;
      acpa_pkg::sm_type q;
      logic             xneg;
      logic [ZW-1:0]    m;
   } nside_type;

   typedef struct packed {
      logic          nneg;
      logic          xneg;
      logic [ZW-1:0] m;
   } dside_type;

   typedef struct packed {
      logic sneg;
      logic xneg;
   } tside_type;

   // sign-magnitude add, result magnitude saturates just below 2^63
   function automatic acpa_pkg::sm_type sm_add(input acpa_pkg::sm_type a,
                                                input acpa_pkg::sm_type b);
      logic [MW+1:0]    sa;
      logic [MW+1:0]    sb;
      logic [MW+1:0]    sum;
      logic [MW+1:0]    mag;
      acpa_pkg::sm_type r;
      sa  = {2'b00, a.mag};
      sb  = {2'b00, b.mag};
      if (a.neg) sa = -sa;
      if (b.neg) sb = -sb;
      sum = sa + sb;
      r.neg = sum[MW+1];
      mag = r.neg ? -sum : sum;
      r.mag = (mag[MW+1:MW] != 2'b00) ? '1 : mag[MW-1:0];
      return r;
   endfunction

   assign busy = 1'b0;

   // front: magnitude of x, clamp to one, align to Q60
   front_type fr_ff;
   front_type fr_in;
   logic      fr_v_ff;

   always_comb begin
      logic [31:0] xmag;
      logic [63:0] xw;
      xmag = req_x_value[31] ? (32'd0 - req_x_value) : req_x_value;
      xw = {32'd0, xmag};
      if (xw > ONE_IN) xw = ONE_IN;
      xw = xw << SH;
      fr_in.xneg = req_x_value[31];
      fr_in.m    = xw[ZW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_v_ff <= 1'b0;
      end else begin
         fr_v_ff <= start && !busy;
      end
      fr_ff <= fr_in;
   end

   // z = x^2
   logic                   z_v;
   logic [0:0][MW-1:0]     z_prod;
   logic [ZW:0]            z_side_vec;
   front_type              z_side;

   acpa_mul #(.LANES(1), .SIDE_W($bits(front_type))) u_mul_z (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_v_ff),
      .in_a      ({{(MW-ZW){1'b0}}, fr_ff.m}),
      .in_b      (fr_ff.m),
      .in_side   (fr_ff),
      .out_valid (z_v),
      .out_prod  (z_prod),
      .out_side  (z_side_vec)
   );
   assign z_side = front_type'(z_side_vec);

   // horner chain, numerator and denominator side by side
   horn_type hin     [POLY_DEGREE];
   logic     hvin    [POLY_DEGREE];
   horn_type hs_ff   [POLY_DEGREE];
   logic     hv_ff   [POLY_DEGREE];

   genvar j;
   generate
      for (j = 0; j < POLY_DEGREE; j++) begin : g_horner
         localparam acpa_pkg::sm_type CP = acpa_pkg::coef_sm(1'b0, POLY_DEGREE - 1 - j);
         localparam acpa_pkg::sm_type CQ = acpa_pkg::coef_sm(1'b1, POLY_DEGREE - 1 - j);
         logic               mv;
         logic [1:0][MW-1:0] prod;
         logic [$bits(hside_type)-1:0] side_vec;
         hside_type          side;
         horn_type           h_in;

         if (j == 0) begin : g_first
            assign hin[0].p    = acpa_pkg::coef_sm(1'b0, POLY_DEGREE);
            assign hin[0].q    = acpa_pkg::coef_sm(1'b1, POLY_DEGREE);
            assign hin[0].z    = z_prod[0][ZW-1:0];
            assign hin[0].xneg = z_side.xneg;
            assign hin[0].m    = z_side.m;
            assign hvin[0]     = z_v;
         end else begin : g_next
            assign hin[j]  = hs_ff[j-1];
            assign hvin[j] = hv_ff[j-1];
         end

         acpa_mul #(.LANES(2), .SIDE_W($bits(hside_type))) u_mul_h (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (hvin[j]),
            .in_a      ({hin[j].p.mag, hin[j].q.mag}),
            .in_b      (hin[j].z),
            .in_side   ({hin[j].p.neg, hin[j].q.neg, hin[j].z, hin[j].xneg, hin[j].m}),
            .out_valid (mv),
            .out_prod  (prod),
            .out_side  (side_vec)
         );
         assign side = hside_type'(side_vec);

         // acc = c_k + acc*z with saturation
         always_comb begin
            h_in.p    = sm_add(CP, {side.pneg, prod[1]});
            h_in.q    = sm_add(CQ, {side.qneg, prod[0]});
            h_in.z    = side.z;
            h_in.xneg = side.xneg;
            h_in.m    = side.m;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               hv_ff[j] <= 1'b0;
            end else begin
               hv_ff[j] <= mv;
            end
            hs_ff[j] <= h_in;
         end
      end
   endgenerate

   // n = z * P
   horn_type                      hl;
   logic                          n_v;
   logic [0:0][MW-1:0]            n_prod;
   logic [$bits(nside_type)-1:0]  n_side_vec;
   nside_type                     n_side;
   dside_type                     d_in_side;

   assign hl = hs_ff[POLY_DEGREE-1];

   acpa_mul #(.LANES(1), .SIDE_W($bits(nside_type))) u_mul_n (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (hv_ff[POLY_DEGREE-1]),
      .in_a      (hl.p.mag),
      .in_b      (hl.z),
      .in_side   ({hl.p.neg, hl.q, hl.xneg, hl.m}),
      .out_valid (n_v),
      .out_prod  (n_prod),
      .out_side  (n_side_vec)
   );
   assign n_side = nside_type'(n_side_vec);

   // a zero product carries no sign
   assign d_in_side.nneg = n_side.pneg && (n_prod[0] != '0);
   assign d_in_side.xneg = n_side.xneg;
   assign d_in_side.m    = n_side.m;

   // r = n / Q
   logic                          d_v;
   logic [acpa_pkg::QUOT_W-1:0]   d_quot;
   logic [$bits(dside_type)-1:0]  d_side_vec;
   dside_type                     d_side;

   acpa_div #(.SIDE_W($bits(dside_type))) u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (n_v),
      .in_dividend (n_prod[0]),
      .in_divisor  (n_side.q),
      .in_side     (d_in_side),
      .out_valid   (d_v),
      .out_quot    (d_quot),
      .out_side    (d_side_vec)
   );
   assign d_side = dside_type'(d_side_vec);

   // s = 1 + r
   acpa_pkg::sm_type s_ff;
   acpa_pkg::sm_type s_in;
   logic             s_xneg_ff;
   logic [ZW-1:0]    s_m_ff;
   logic             s_v_ff;

   assign s_in = sm_add({1'b0, acpa_pkg::ONE_Q60[MW-1:0]},
                        {d_side.nneg, {(MW-acpa_pkg::QUOT_W){1'b0}}, d_quot});

   always_ff @(posedge clock) begin
      if (reset) begin
         s_v_ff <= 1'b0;
      end else begin
         s_v_ff <= d_v;
      end
      s_ff      <= s_in;
      s_xneg_ff <= d_side.xneg;
      s_m_ff    <= d_side.m;
   end

   // t = |x| * (1 + r)
   logic                          t_v;
   logic [0:0][MW-1:0]            t_prod;
   logic [$bits(tside_type)-1:0]  t_side_vec;
   tside_type                     t_side;

   acpa_mul #(.LANES(1), .SIDE_W($bits(tside_type))) u_mul_t (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_v_ff),
      .in_a      (s_ff.mag),
      .in_b      (s_m_ff),
      .in_side   ({s_ff.neg, s_xneg_ff}),
      .out_valid (t_v),
      .out_prod  (t_prod),
      .out_side  (t_side_vec)
   );
   assign t_side = tside_type'(t_side_vec);

   // pi/2 - t for positive x, pi/2 + t for negative x
   acpa_pkg::sm_type res_ff;
   logic             res_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_v_ff <= 1'b0;
      end else begin
         res_v_ff <= t_v;
      end
      res_ff <= sm_add({1'b0, acpa_pkg::HALF_PI[MW-1:0]},
                       {t_side.sneg ^ !t_side.xneg, t_prod[0]});
   end

   // clamp to 0..pi, round to nearest, narrow
   logic [31:0] angle_ff;
   logic [31:0] angle_in;
   logic        out_v_ff;

   always_comb begin
      logic [63:0] c;
      logic [63:0] sh;
      if (res_ff.neg) begin
         c = 64'd0;
      end else if ({1'b0, res_ff.mag} > acpa_pkg::PI) begin
         c = acpa_pkg::PI;
      end else begin
         c = {1'b0, res_ff.mag};
      end
      sh = (c + ROUND_HALF) >> SH;
      angle_in = sh[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= res_v_ff;
      end
      angle_ff <= angle_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_angle = angle_ff;

endmodule

FILE: sim/arccos_pade_approximant_top_tb.sv
module arccos_pade_approximant_top_tb;

   // q60 fixed point used by the angle predictor
   localparam int FRACQ = 60;
   localparam int XFRAC = 30;
   localparam logic [63:0] ONE_Q = 64'd1 << FRACQ;
   localparam logic [63:0] QUOT_SAT = (64'd1 << 62) - 64'd1;
   localparam logic [63:0] DEC_ONE = 64'd1000000000000000000;
   localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] HALF_PI_DEC = 64'd1570796326794896619;
   // extra drain once every expected angle is seen, with a margin
   localparam int DRAIN_CYCLES = 100;
   localparam int STALL_LIMIT = 3000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_x_value;
   logic        rsp_valid;
   logic [31:0] rsp_angle;

   arccos_pade_approximant_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_x_value (req_x_value),
      .rsp_valid   (rsp_valid),
      .rsp_angle   (rsp_angle)
   );

   logic [31:0] angle_queue[$];
   int          mismatches;
   int          idle_cycles;
   bit          take_now;
   logic [31:0] take_x;
   bit          gaps_on;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // ---------------- angle predictor ----------------

   // floor(a*b / 2^60) on magnitudes
   function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // floor(a * 2^60 / b), saturating once the quotient reaches four
   function automatic logic [63:0] div_q(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] w;
      if (b == 64'd0 || a / b >= 64'd4) return QUOT_SAT;
      w = {64'd0, a} << FRACQ;
      w = w / {64'd0, b};
      return w[63:0];
   endfunction

   function automatic logic signed [63:0] signed_of(input bit neg, input logic [63:0] mag);
      logic [63:0] m;
      m = (mag > S64_MAX) ? S64_MAX : mag;
      return neg ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [63:0] smul_q(input logic signed [63:0] a,
                                                  input logic [63:0] z);
      bit          neg;
      logic [63:0] m;
      neg = a < 0;
      m = neg ? -a : a;
      return signed_of(neg, mul_q(m, z));
   endfunction

   // saturating add, lower bound is min+1 so the magnitude always fits
   function automatic logic signed [63:0] sadd_q(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7fff_ffff_ffff_ffff) return $signed(S64_MAX);
      if (s < -65'sh0_7fff_ffff_ffff_ffff) return -$signed(S64_MAX);
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] coef_q(input bit den, input int k);
      logic [63:0] nd[7];
      logic [63:0] dd[7];
      bit   [6:0]  nn;
      bit   [6:0]  dn;
      nd = '{64'd166666666666666667, 64'd451834677893154506, 64'd452683382858399539,
             64'd204511700745869575, 64'd40161699156136797, 64'd2604361227231504,
             64'd8529836515897};
      dd = '{64'd1000000000000000000, 64'd3161008067358927034, 64'd3870696784604771541,
             64'd2304476834742890138, 64'd683183463380740736, 64'd91189047491786683,
             64'd3926844788854131};
      nn = 7'b0101010;
      dn = 7'b0101010;
      if (den) return signed_of(dn[k], div_q(dd[k], DEC_ONE));
      return signed_of(nn[k], div_q(nd[k], DEC_ONE));
   endfunction

   function automatic logic signed [63:0] horner_q(input bit den, input logic [63:0] z);
      logic signed [63:0] acc;
      acc = coef_q(den, 6);
      for (int k = 5; k >= 0; k--) acc = sadd_q(coef_q(den, k), smul_q(acc, z));
      return acc;
   endfunction

   function automatic logic [31:0] arccos_expected(input logic [31:0] x);
      bit                 xneg;
      bit                 nneg;
      logic [63:0]        xmag;
      logic [63:0]        m;
      logic [63:0]        z;
      logic [63:0]        rmag;
      logic [63:0]        half_pi;
      logic [63:0]        res_u;
      logic signed [63:0] p;
      logic signed [63:0] q;
      logic signed [63:0] n;
      logic signed [63:0] r;
      logic signed [63:0] t;
      logic signed [63:0] res;
      xneg = x[31];
      xmag = xneg ? (64'd1 << 32) - {32'd0, x} : {32'd0, x};
      // beyond one saturates to one, sign kept
      if (xmag > (64'd1 << XFRAC)) xmag = 64'd1 << XFRAC;
      m = xmag << (FRACQ - XFRAC);
      z = mul_q(m, m);
      p = horner_q(1'b0, z);
      q = horner_q(1'b1, z);
      n = smul_q(p, z);
      nneg = n < 0;
      // degenerate denominator saturates the ratio
      rmag = (q <= 0) ? QUOT_SAT : div_q(nneg ? -n : n, q);
      r = signed_of(nneg, rmag);
      t = smul_q($signed(ONE_Q) + r, m);
      half_pi = div_q(HALF_PI_DEC, DEC_ONE);
      res = xneg ? $signed(half_pi) + t : $signed(half_pi) - t;
      if (res < 0) res = 0;
      if (res > $signed(half_pi << 1)) res = $signed(half_pi << 1);
      res_u = (res + (64'd1 << (FRACQ - XFRAC - 1))) >> (FRACQ - XFRAC);
      return res_u[31:0];
   endfunction

   // ---------------- monitors ----------------

   // sample at the falling edge so nothing races the rising-edge updates
   always @(negedge clock) begin
      take_now <= !reset && start && !busy;
      take_x <= req_x_value;
      if (!reset && rsp_valid) begin
         if (angle_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result angle=%h", rsp_angle);
         end else begin
            logic [31:0] want;
            want = angle_queue.pop_front();
            if (rsp_angle !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("angle mismatch: expected %h actual %h", want, rsp_angle);
            end
         end
      end
   end

   // queue the expected angle for every item taken at this edge
   always @(posedge clock) begin
      if (take_now) angle_queue.push_back(arccos_expected(take_x));
   end

   // watchdog: too many cycles with nothing moving on either side
   always @(posedge clock) begin
      if (reset || take_now || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("arccos_pade_approximant_top_tb NOT OK");
         $finish;
      end
   end

   // ---------------- stimulus ----------------

   // mostly short gaps, now and then a long one
   task automatic idle_gap();
      int n;
      if (!gaps_on || $urandom_range(0, 99) < 55) return;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 4);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // one item: hold start until the block takes it
   task automatic send_x(input logic [31:0] x);
      start <= 1'b1;
      req_x_value <= x;
      do @(posedge clock); while (!take_now);
      idle_gap();
   endtask

   function automatic logic [31:0] random_x();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 65) return $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      // close to plus or minus one, where the rational part works hardest
      if (sel < 85) begin
         logic [31:0] near;
         near = 32'h4000_0000 - $urandom_range(0, 32'h0100_0000);
         return $urandom_range(0, 1) ? near : -near;
      end
      return $urandom();
   endfunction

   // field extremes, zero, the sign boundary and arguments past one
   task automatic test_edges();
      logic [31:0] pts[$];
      gaps_on = 1'b1;
      pts = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h4000_0000, 32'hc000_0000,
              32'h4000_0001, 32'hbfff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h2000_0000,
              32'he000_0000, 32'h3fff_ffff, 32'hc000_0001, 32'h3ddb_3d74, 32'hc224_c28c,
              32'h0010_0000, 32'hfff0_0000, 32'h5555_5555, 32'haaaa_aaaa};
      foreach (pts[i]) send_x(pts[i]);
   endtask

   // random arguments with random gaps between items
   task automatic test_random_gaps(input int count);
      gaps_on = 1'b1;
      repeat (count) send_x(random_x());
   endtask

   // one item every cycle, the pipe full throughout
   task automatic test_streaming(input int count);
      gaps_on = 1'b0;
      repeat (count) send_x(random_x());
   endtask

   initial begin
      mismatches = 0;
      idle_cycles = 0;
      take_now = 1'b0;
      gaps_on = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_x_value = 32'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edges();
      test_random_gaps(400);
      test_streaming(200);
      test_random_gaps(150);

      start <= 1'b0;
      while (angle_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("arccos_pade_approximant_top_tb OK");
      end else begin
         $display("arccos_pade_approximant_top_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/acpa_pkg.sv
rtl/acpa_mul.sv
rtl/acpa_div.sv
rtl/arccos_pade_approximant_top.sv
sim/arccos_pade_approximant_top_tb.sv
